// ===== rtl/json_string_unescape_unit_macros.svh =====
// Assertion macros shared by the string unescape unit.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef JSON_STRING_UNESCAPE_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UNIT_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define JSU_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define JSU_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and decode functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Decoder modes. The unused code is treated as plain mode.
	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_UHEX  = 2'd2
	} mode_t;

	// Up to three output bytes produced by one input byte.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
	} emit_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;

	localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;

	// Map the character after a backslash to the byte it stands for.
	function automatic logic [7:0] esc_map(logic [7:0] e);
		case (e)
			CH_N:    return 8'h0A;
			CH_R:    return 8'h0D;
			CH_T:    return 8'h09;
			CH_B:    return 8'h08;
			CH_F:    return 8'h0C;
			default: return e;
		endcase
	endfunction

	// Hex digit check; the top bit flags a valid digit.
	function automatic logic [4:0] hex_digit(logic [7:0] h);
		if (h inside {[CH_0:CH_9]}) begin
			return {1'b1, h[3:0]};
		end else if (h inside {[CH_LA:CH_F], [CH_UA:CH_UF]}) begin
			return {1'b1, h[3:0] + 4'd9};
		end else begin
			return 5'd0;
		end
	endfunction

	// Value of four collected characters; any non-hex character gives U+FFFD.
	function automatic logic [15:0] hex_value(logic [7:0] q0, logic [7:0] q1,
			logic [7:0] q2, logic [7:0] q3);
		logic [4:0] d0;
		logic [4:0] d1;
		logic [4:0] d2;
		logic [4:0] d3;
		d0 = hex_digit(q0);
		d1 = hex_digit(q1);
		d2 = hex_digit(q2);
		d3 = hex_digit(q3);
		if (d0[4] && d1[4] && d2[4] && d3[4]) begin
			return {d0[3:0], d1[3:0], d2[3:0], d3[3:0]};
		end else begin
			return REPLACEMENT_CHAR;
		end
	endfunction

	// UTF-8 encoding of a 16-bit code point in one to three bytes.
	function automatic emit_t utf8_enc(logic [15:0] v);
		emit_t r;
		r = '0;
		if (v < 16'h0080) begin
			r.bytes[0] = v[7:0];
			r.cnt      = 2'd1;
		end else if (v < 16'h0800) begin
			r.bytes[0] = 8'hC0 | {3'b000, v[10:6]};
			r.bytes[1] = 8'h80 | {2'b00, v[5:0]};
			r.cnt      = 2'd2;
		end else begin
			r.bytes[0] = 8'hE0 | {4'b0000, v[15:12]};
			r.bytes[1] = 8'h80 | {2'b00, v[11:6]};
			r.bytes[2] = 8'h80 | {2'b00, v[5:0]};
			r.cnt      = 2'd3;
		end
		return r;
	endfunction

	// Plain-rule decode of up to three characters left over when a string
	// ends inside a unicode escape. The fourth entry is padding.
	function automatic emit_t tail_decode(logic [3:0][7:0] c, logic [1:0] n);
		emit_t r;
		logic  skip;
		r    = '0;
		skip = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (k < int'(n)) begin
				if (skip) begin
					skip = 1'b0;
				end else if (c[k] != CH_BSLASH) begin
					r.bytes[r.cnt] = c[k];
					r.cnt          = r.cnt + 2'd1;
				end else if ((k + 1) < int'(n)) begin
					// A short unicode escape drops its u.
					if (c[k + 1] != CH_U) begin
						r.bytes[r.cnt] = esc_map(c[k + 1]);
						r.cnt          = r.cnt + 2'd1;
					end
					skip = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/json_string_unescape_unit.sv =====
// Each input byte is held in the input register and its result is then loaded
// into the result buffer, where it is offered; the byte waits while the buffer is busy.
// Throughput: one input byte per cycle while the result buffer can take it; each
// result byte needs one output transfer, and the single-entry result buffer shifts
// out one byte per transfer, so an n-byte result holds the input until its last byte goes.
// Reset: arst_n clears the decoder state and both valid flags asynchronously.
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Unescapes the body of a JSON string, one raw byte in and one output byte (or a
// bare end marker) out per transfer, with unicode escapes encoded as UTF-8.
// ----------------------------------------------------------------------------
`include "json_string_unescape_unit_macros.svh"

module json_string_unescape_unit
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_end,
	output logic       string_end
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Decoder state.
	mode_t           mode_q;
	logic [1:0]      held_cnt_q;
	logic [2:0][7:0] held_q;

	// Result buffer; byte zero is the one on offer.
	logic            res_valid_q;
	logic [2:0][7:0] res_bytes_q;
	logic [1:0]      res_cnt_q;
	logic            res_has_q;
	logic            res_last_q;

	mode_t           mode_d;
	logic [1:0]      cnt_d;
	logic [2:0][7:0] held_d;
	emit_t           em;

	logic in_xfer;
	logic out_xfer;
	logic buf_free;
	logic load;

	// Handshake control.
	assign out_xfer = res_valid_q && !out_stall;
	assign buf_free = !res_valid_q || (out_xfer && res_cnt_q == 2'd1);
	assign load     = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;
	assign in_xfer  = in_valid && !in_stall;

	// Decode of the registered byte against the current state.
	always_comb begin
		mode_d = mode_q;
		cnt_d  = held_cnt_q;
		held_d = held_q;
		em     = '0;
		case (mode_q)
			MODE_ESC: begin
				if (byte_s1 == CH_U) begin
					mode_d = MODE_UHEX;
					cnt_d  = 2'd0;
				end else begin
					em.bytes[0] = esc_map(byte_s1);
					em.cnt      = 2'd1;
					mode_d      = MODE_PLAIN;
				end
			end
			MODE_UHEX: begin
				if (held_cnt_q == 2'd3) begin
					em     = utf8_enc(hex_value(held_q[0], held_q[1], held_q[2], byte_s1));
					mode_d = MODE_PLAIN;
					cnt_d  = 2'd0;
				end else begin
					held_d[held_cnt_q] = byte_s1;
					cnt_d              = held_cnt_q + 2'd1;
				end
			end
			default: begin
				if (byte_s1 == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					em.bytes[0] = byte_s1;
					em.cnt      = 2'd1;
					mode_d      = MODE_PLAIN;
				end
			end
		endcase
		// End of string: flush a short unicode escape and return to reset state.
		if (last_s1) begin
			if (mode_d == MODE_UHEX) begin
				em = tail_decode({8'h00, held_d}, cnt_d);
			end
			mode_d = MODE_PLAIN;
			cnt_d  = 2'd0;
			held_d = '0;
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_byte;
			last_s1 <= is_last;
		end
	end

	// Decoder state advances when the registered byte moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_PLAIN;
			held_cnt_q <= 2'd0;
			held_q     <= '0;
		end else if (load) begin
			mode_q     <= mode_d;
			held_cnt_q <= cnt_d;
			held_q     <= held_d;
		end
	end

	// Result buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= (em.cnt != 2'd0) || last_s1;
		end else if (out_xfer && res_cnt_q == 2'd1) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result buffer payload; a transfer shifts the next byte into place.
	always_ff @(posedge clk) begin
		if (load) begin
			if (em.cnt == 2'd0) begin
				// Bare end marker.
				res_bytes_q <= '0;
				res_cnt_q   <= 2'd1;
				res_has_q   <= 1'b0;
			end else begin
				res_bytes_q <= em.bytes;
				res_cnt_q   <= em.cnt;
				res_has_q   <= 1'b1;
			end
			res_last_q <= last_s1;
		end else if (out_xfer) begin
			res_bytes_q <= {8'h00, res_bytes_q[2:1]};
			res_cnt_q   <= res_cnt_q - 2'd1;
		end
	end

	// Output ports.
	assign out_valid  = res_valid_q;
	assign out_byte   = res_bytes_q[0];
	assign has_byte   = res_has_q;
	assign run_end    = (res_cnt_q == 2'd1);
	assign string_end = (res_cnt_q == 2'd1) && res_last_q;

	// Checks on the buffer and the decoder state.
	`JSU_ASSERT_SAME(a_cnt_nonzero, res_valid_q, res_cnt_q != 2'd0,
		"empty result buffer shown as valid")
	`JSU_ASSERT_SAME(a_marker_alone, res_valid_q && !res_has_q,
		res_cnt_q == 2'd1 && res_last_q, "end marker is not a lone final result")
	`JSU_ASSERT_SAME(a_stall_pending, in_stall, valid_s1 && res_valid_q,
		"input stalled with nothing pending")
	`JSU_ASSERT_NEXT(a_end_resets, load && last_s1,
		mode_q == MODE_PLAIN && held_cnt_q == 2'd0, "state not cleared at end of string")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the JSON string unescape unit. A software
// decoder predicts the output bytes of every accepted input transfer, and a
// monitor compares each output transfer with the oldest prediction. Directed
// strings cover the corner cases; random strings built from escape tokens,
// random output stalls and a long output hold cover the rest.
// ----------------------------------------------------------------------------
module tb_top
	import jsu_pkg::*;
();

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	// One output transfer of the unit.
	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       run_last;
		logic       str_last;
	} unesc_result_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic [7:0] in_byte    = 8'h00;
	logic       is_last    = 1'b0;
	logic       out_stall  = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       run_end;
	logic       string_end;

	unesc_result_t expected_results[$];
	logic [7:0]    raw_bytes[$];
	logic [7:0]    decoded_bytes[$];

	// Predictor state.
	mode_t      dec_mode = MODE_PLAIN;
	logic [1:0] held_n   = 2'd0;
	logic [7:0] held_q [0:2];

	int mismatch_count = 0;
	int items_sent     = 0;
	bit idle_on        = 1'b1;
	bit hold_armed     = 1'b0;
	int hold_left      = 0;
	int stall_left     = 0;

	json_string_unescape_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

	always #5 clk = ~clk;

	// Run limit, far above the slowest legal run.
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Value of a hex character, or -1 if it is not one.
	function automatic int hex_val(logic [7:0] h);
		if (h >= CH_0 && h <= CH_9) begin
			return int'(h - CH_0);
		end else if (h >= CH_LA && h <= CH_F) begin
			return int'(h - CH_LA) + 10;
		end else if (h >= CH_UA && h <= CH_UF) begin
			return int'(h - CH_UA) + 10;
		end
		return -1;
	endfunction

	// Byte that the character after a backslash stands for.
	function automatic logic [7:0] map_escape(logic [7:0] e);
		case (e)
			CH_N:    return 8'h0A;
			CH_R:    return 8'h0D;
			CH_T:    return 8'h09;
			CH_B:    return 8'h08;
			CH_F:    return 8'h0C;
			default: return e;
		endcase
	endfunction

	// Append the UTF-8 form of a code point to the decoded bytes.
	function automatic void add_utf8(logic [15:0] v);
		if (v < 16'h0080) begin
			decoded_bytes.push_back(v[7:0]);
		end else if (v < 16'h0800) begin
			decoded_bytes.push_back({3'b110, v[10:6]});
			decoded_bytes.push_back({2'b10, v[5:0]});
		end else begin
			decoded_bytes.push_back({4'b1110, v[15:12]});
			decoded_bytes.push_back({2'b10, v[11:6]});
			decoded_bytes.push_back({2'b10, v[5:0]});
		end
	endfunction

	// Work out the output transfers caused by one accepted input byte.
	function automatic void predict_unescape(logic [7:0] b, logic last);
		mode_t      m;
		logic [15:0] v;
		logic [7:0] c;
		bit         bad;
		int         d;
		int         i;
		int         n;
		unesc_result_t r;
		m = dec_mode;
		decoded_bytes.delete();
		case (m)
			MODE_ESC: begin
				if (b == CH_U) begin
					m      = MODE_UHEX;
					held_n = 2'd0;
				end else begin
					decoded_bytes.push_back(map_escape(b));
					m = MODE_PLAIN;
				end
			end
			MODE_UHEX: begin
				if (held_n == 2'd3) begin
					v   = 16'h0000;
					bad = 1'b0;
					for (int k = 0; k < 4; k++) begin
						d = hex_val((k < 3) ? held_q[k] : b);
						if (d < 0) begin
							bad = 1'b1;
						end else begin
							v = {v[11:0], 4'(d)};
						end
					end
					add_utf8(bad ? REPLACEMENT_CHAR : v);
					m      = MODE_PLAIN;
					held_n = 2'd0;
				end else begin
					held_q[held_n] = b;
					held_n         = held_n + 2'd1;
				end
			end
			default: begin
				// The unused mode code behaves as plain mode.
				if (b == CH_BSLASH) begin
					m = MODE_ESC;
				end else begin
					decoded_bytes.push_back(b);
					m = MODE_PLAIN;
				end
			end
		endcase

		if (last) begin
			// A short unicode escape: drop the u and decode what was held.
			if (m == MODE_UHEX) begin
				i = 0;
				n = int'(held_n);
				while (i < n) begin
					c = held_q[i];
					i++;
					if (c != CH_BSLASH) begin
						decoded_bytes.push_back(c);
					end else if (i < n) begin
						c = held_q[i];
						i++;
						if (c != CH_U) begin
							decoded_bytes.push_back(map_escape(c));
						end
					end
				end
			end
			dec_mode = MODE_PLAIN;
			held_n   = 2'd0;
			for (int k = 0; k < 3; k++) begin
				held_q[k] = 8'h00;
			end
		end else begin
			dec_mode = m;
		end

		if (decoded_bytes.size() == 0) begin
			if (last) begin
				r = '{data: 8'h00, has: 1'b0, run_last: 1'b1, str_last: 1'b1};
				expected_results.push_back(r);
			end
		end else begin
			n = decoded_bytes.size();
			for (int k = 0; k < n; k++) begin
				r.data     = decoded_bytes[k];
				r.has      = 1'b1;
				r.run_last = (k == n - 1);
				r.str_last = (k == n - 1) && last;
				expected_results.push_back(r);
			end
		end
	endfunction

	// Send one input byte and wait for its transfer.
	task automatic send_item(input logic [7:0] b, input logic last);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		is_last  <= last;
		do begin
			@(posedge clk);
		end while (in_stall);
		predict_unescape(b, last);
		items_sent++;
	endtask

	// Send the queued raw bytes as one string, marking the final byte.
	task automatic send_string();
		int n;
		n = raw_bytes.size();
		for (int i = 0; i < n; i++) begin
			send_item(raw_bytes[i], i == n - 1);
		end
		raw_bytes.delete();
	endtask

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			raw_bytes.push_back(s[i]);
		end
	endfunction

	// Hex character for a digit, with the case of letters chosen at random.
	function automatic logic [7:0] hex_char(logic [3:0] d);
		if (d < 4'd10) begin
			return CH_0 + 8'(d);
		end
		return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 4'd10);
	endfunction

	// Append one random token of a string body.
	function automatic void add_token();
		logic [15:0] v;
		logic [7:0]  b;
		int          bad_pos;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				raw_bytes.push_back(8'($urandom_range(0, 255)));
			end
			3, 4: begin
				raw_bytes.push_back(CH_BSLASH);
				case ($urandom_range(0, 8))
					0:       b = CH_DQUOTE;
					1:       b = CH_BSLASH;
					2:       b = CH_SLASH;
					3:       b = CH_N;
					4:       b = CH_R;
					5:       b = CH_T;
					6:       b = CH_B;
					7:       b = CH_F;
					default: b = 8'($urandom_range(0, 255));
				endcase
				raw_bytes.push_back(b);
			end
			5, 6, 7, 8: begin
				// Unicode escape spread over the one, two and three byte ranges.
				case ($urandom_range(0, 2))
					0:       v = 16'($urandom_range(0, 16'h007F));
					1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
					default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
				endcase
				bad_pos = $urandom_range(0, 7);
				raw_bytes.push_back(CH_BSLASH);
				raw_bytes.push_back(CH_U);
				for (int k = 0; k < 4; k++) begin
					if (k == bad_pos) begin
						raw_bytes.push_back(8'($urandom_range(0, 255)));
					end else begin
						raw_bytes.push_back(hex_char(v[15 - 4 * k -: 4]));
					end
				end
			end
			default: begin
				raw_bytes.push_back(CH_BSLASH);
				raw_bytes.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	// Build a random string, sometimes cut short inside a token, and send it.
	task automatic send_random_string(input int max_tokens);
		int ntok;
		int cut;
		ntok = $urandom_range(1, max_tokens);
		for (int i = 0; i < ntok; i++) begin
			add_token();
		end
		if ($urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, raw_bytes.size());
			while (raw_bytes.size() > cut) begin
				void'(raw_bytes.pop_back());
			end
		end
		send_string();
	endtask

	// Stop offering and wait until every predicted transfer has arrived.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Corner cases: extreme bytes, zero and maximum code points, a bad hex
	// digit, strings cut inside a unicode escape, and a lone final backslash.
	task automatic test_directed_cases();
		raw_bytes.push_back(8'h00);
		raw_bytes.push_back(8'hFF);
		push_text("\\n\\u0000\\uFFFF");
		send_string();
		push_text("\\u07g0");
		send_string();
		push_text("\\u4");
		send_string();
		push_text("\\ua\\u");
		send_string();
		push_text("\\");
		send_string();
	endtask

	// Random strings with random idling on both sides.
	task automatic test_random_strings();
		while (items_sent < 380) begin
			send_random_string(6);
		end
	endtask

	// The output holds off for a long stretch while three-byte escapes keep
	// arriving, so the unit fills up and stalls its input.
	task automatic test_output_hold();
		hold_armed = 1'b1;
		for (int i = 0; i < 5; i++) begin
			push_text("\\uABCD");
		end
		send_string();
	endtask

	// Back-to-back transfers with no idling on either side.
	task automatic test_full_rate();
		idle_on = 1'b0;
		while (items_sent < 460) begin
			send_random_string(4);
		end
	endtask

	// Output monitor and stall generator.
	always @(posedge clk) begin
		unesc_result_t got;
		unesc_result_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {out_byte, has_byte, run_end, string_end};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected transfer: byte=%02h has=%b run_end=%b string_end=%b",
						$time, got.data, got.has, got.run_last, got.str_last);
					mismatch_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						$display({"%0t: mismatch: expected byte=%02h has=%b run_end=%b ",
							"string_end=%b, actual byte=%02h has=%b run_end=%b string_end=%b"},
							$time, exp_r.data, exp_r.has, exp_r.run_last, exp_r.str_last,
							got.data, got.has, got.run_last, got.str_last);
						mismatch_count++;
					end
				end
			end

			if (hold_armed) begin
				hold_armed = 1'b0;
				hold_left  = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Test sequence.
	initial begin
		for (int k = 0; k < 3; k++) begin
			held_q[k] = 8'h00;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		wait_idle();
		test_random_strings();
		wait_idle();
		test_output_hold();
		wait_idle();
		test_full_rate();
		wait_idle();
		repeat (10) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected transfers never arrived", $time,
				expected_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jsu_pkg.sv
rtl/json_string_unescape_unit.sv
tb/tb_top.sv
